>>> rtl/core/csr_pkg.sv
// Shared types and constants for the Courant step reduction block.
// Depends on nothing; every csr_* module refers to it by scoped names.
`default_nettype none

package csr_pkg;

  // Mesh geometry
  localparam int unsigned NODES_PER_ELEMENT = 27;
  localparam int unsigned Axes              = 3;

  // Field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned SumW   = 37;
  localparam int unsigned ExtW   = 32;
  localparam int unsigned QuoW   = 32;
  localparam int unsigned FracW  = 16;

  // Widths derived from the node count
  localparam int unsigned NodesW = $clog2(NODES_PER_ELEMENT + 1);
  localparam int unsigned ProdW  = ExtW + NodesW;
  localparam int unsigned CntW   = $clog2(QuoW);

  // Job queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Reset and saturation values
  localparam logic [CoordW-1:0] CoordMost  = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CoordLeast = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [SumW-1:0]   SumMax     = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0]   SumMin     = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [QuoW-1:0]   StepSat    = {QuoW{1'b1}};

  // One closed element, waiting for the divider
  typedef struct packed {
    logic [Axes-1:0][ExtW-1:0] ext;
    logic [Axes-1:0][SumW-1:0] vsum;
    logic                      eom;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/core/csr_front.sv
// Front end: accepts mesh nodes, tracks per-element extents and velocity sums.
// Depends on csr_pkg; pushes one job per closed element into csr_queue.
`default_nettype none

module csr_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [191:0]           s_tdata,  // node_x, node_y, node_z, vel_x, vel_y, vel_z
  input  wire logic                   s_tlast,  // end_of_element
  input  wire logic [0:0]             s_tuser,  // end_of_mesh
  input  wire csr_pkg::q_status_t     q_stat,
  output logic                        push,
  output csr_pkg::job_t               job
);

  logic [csr_pkg::CoordW-1:0] axis_min [csr_pkg::Axes];
  logic [csr_pkg::CoordW-1:0] axis_max [csr_pkg::Axes];
  logic [csr_pkg::SumW-1:0]   velocity_sum [csr_pkg::Axes];

  logic [csr_pkg::CoordW-1:0] coord [csr_pkg::Axes];
  logic [csr_pkg::CoordW-1:0] vel [csr_pkg::Axes];
  logic [csr_pkg::CoordW-1:0] min_next [csr_pkg::Axes];
  logic [csr_pkg::CoordW-1:0] max_next [csr_pkg::Axes];
  logic [csr_pkg::SumW-1:0]   sum_next [csr_pkg::Axes];
  logic [csr_pkg::SumW:0]     sum_wide [csr_pkg::Axes];
  logic [csr_pkg::CoordW:0]   span [csr_pkg::Axes];

  logic accept;
  logic close;

  assign s_tready = !rst && !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign close    = s_tlast || s_tuser[0];
  assign push     = accept && close;

  // Fold the incoming node into each axis lane
  always_comb begin
    for (int a = 0; a < csr_pkg::Axes; a++) begin
      coord[a] = s_tdata[a*csr_pkg::CoordW +: csr_pkg::CoordW];
      vel[a]   = s_tdata[(csr_pkg::Axes + a)*csr_pkg::CoordW +: csr_pkg::CoordW];

      min_next[a] = ($signed(coord[a]) < $signed(axis_min[a])) ? coord[a] : axis_min[a];
      max_next[a] = ($signed(coord[a]) > $signed(axis_max[a])) ? coord[a] : axis_max[a];

      sum_wide[a] = {velocity_sum[a][csr_pkg::SumW-1], velocity_sum[a]}
                  + {{(csr_pkg::SumW+1-csr_pkg::CoordW){vel[a][csr_pkg::CoordW-1]}}, vel[a]};
      if (sum_wide[a][csr_pkg::SumW] != sum_wide[a][csr_pkg::SumW-1]) begin
        sum_next[a] = sum_wide[a][csr_pkg::SumW] ? csr_pkg::SumMin : csr_pkg::SumMax;
      end else begin
        sum_next[a] = sum_wide[a][csr_pkg::SumW-1:0];
      end

      // Extent clamps at zero
      span[a] = {max_next[a][csr_pkg::CoordW-1], max_next[a]}
              - {min_next[a][csr_pkg::CoordW-1], min_next[a]};
      job.ext[a]  = span[a][csr_pkg::CoordW] ? '0 : span[a][csr_pkg::ExtW-1:0];
      job.vsum[a] = sum_next[a];
    end
    job.eom = s_tuser[0];
  end

  // Hold element state; clear it once the element closes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < csr_pkg::Axes; a++) begin
        axis_min[a]     <= csr_pkg::CoordMost;
        axis_max[a]     <= csr_pkg::CoordLeast;
        velocity_sum[a] <= '0;
      end
    end else if (accept) begin
      for (int a = 0; a < csr_pkg::Axes; a++) begin
        if (close) begin
          axis_min[a]     <= csr_pkg::CoordMost;
          axis_max[a]     <= csr_pkg::CoordLeast;
          velocity_sum[a] <= '0;
        end else begin
          axis_min[a]     <= min_next[a];
          axis_max[a]     <= max_next[a];
          velocity_sum[a] <= sum_next[a];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csr_queue.sv
// Short job queue between the node front end and the divider back end.
// Depends on csr_pkg for the job type and depth.
`default_nettype none

module csr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire csr_pkg::job_t      wr_job,
  input  wire logic               pop,
  output csr_pkg::job_t           rd_job,
  output csr_pkg::q_status_t      stat
);

  csr_pkg::job_t               entries [csr_pkg::QDepth];
  logic [csr_pkg::QPtrW-1:0]   wr_ptr;
  logic [csr_pkg::QPtrW-1:0]   rd_ptr;
  logic [csr_pkg::QCntW-1:0]   count;

  assign rd_job     = entries[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == csr_pkg::QCntW'(csr_pkg::QDepth));

  // Write the entry; payload needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == csr_pkg::QPtrW'(csr_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == csr_pkg::QPtrW'(csr_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csr_back.sv
// Back end: three radix-2 divider lanes, element minimum and running minimum.
// Depends on csr_pkg; takes jobs from csr_queue and drives the result stream.
`default_nettype none

module csr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csr_pkg::q_status_t q_stat,
  input  wire csr_pkg::job_t      q_job,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [63:0]             m_tdata,  // element_step, running_step
  output logic                    m_tlast   // final_result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state;
  logic [csr_pkg::CntW-1:0]    cnt;
  logic                        eom;
  logic [csr_pkg::QuoW-1:0]    least_step;
  logic [csr_pkg::QuoW-1:0]    element_step;
  logic [csr_pkg::QuoW-1:0]    running_step;

  // Divider lane registers
  logic [csr_pkg::SumW-1:0]    rem [csr_pkg::Axes];
  logic [csr_pkg::SumW-1:0]    mag [csr_pkg::Axes];
  logic [csr_pkg::QuoW-1:0]    low [csr_pkg::Axes];
  logic [csr_pkg::QuoW-1:0]    quo [csr_pkg::Axes];
  logic                        sat [csr_pkg::Axes];

  // Lane logic
  logic [csr_pkg::ProdW-1:0]   prod [csr_pkg::Axes];
  logic [csr_pkg::SumW-1:0]    hi_ext [csr_pkg::Axes];
  logic [csr_pkg::SumW-1:0]    mag_in [csr_pkg::Axes];
  logic                        ovf_in [csr_pkg::Axes];
  logic [csr_pkg::SumW:0]      trial [csr_pkg::Axes];
  logic [csr_pkg::SumW:0]      trial_diff [csr_pkg::Axes];
  logic                        fits [csr_pkg::Axes];
  logic [csr_pkg::QuoW-1:0]    axis_step [csr_pkg::Axes];

  logic [csr_pkg::QuoW-1:0]    pair_min;
  logic [csr_pkg::QuoW-1:0]    el_min;
  logic [csr_pkg::QuoW-1:0]    run_min;
  logic                        out_free;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && q_stat.valid;

  // Prepare dividend and divisor, and take one quotient bit per cycle
  always_comb begin
    for (int a = 0; a < csr_pkg::Axes; a++) begin
      prod[a]   = csr_pkg::ProdW'(q_job.ext[a])
                * csr_pkg::ProdW'(csr_pkg::NODES_PER_ELEMENT);
      hi_ext[a] = csr_pkg::SumW'(prod[a][csr_pkg::ProdW-1:csr_pkg::FracW]);
      mag_in[a] = q_job.vsum[a][csr_pkg::SumW-1] ? (~q_job.vsum[a] + 1'b1) : q_job.vsum[a];
      // A zero divisor always lands here as well
      ovf_in[a] = (hi_ext[a] >= mag_in[a]);

      trial[a]      = {rem[a], low[a][csr_pkg::QuoW-1]};
      trial_diff[a] = trial[a] - {1'b0, mag[a]};
      fits[a]       = (trial[a] >= {1'b0, mag[a]});

      axis_step[a]  = sat[a] ? csr_pkg::StepSat : quo[a];
    end
  end

  // Reduce the three axis steps and fold into the running minimum
  always_comb begin
    pair_min = (axis_step[1] < axis_step[0]) ? axis_step[1] : axis_step[0];
    el_min   = (axis_step[2] < pair_min) ? axis_step[2] : pair_min;
    run_min  = (el_min < least_step) ? el_min : least_step;
  end

  // Divider lanes: load from the queue, then shift and subtract
  always_ff @(posedge clk) begin
    for (int a = 0; a < csr_pkg::Axes; a++) begin
      if (pop) begin
        mag[a] <= mag_in[a];
        sat[a] <= ovf_in[a];
        rem[a] <= ovf_in[a] ? '0 : hi_ext[a];
        low[a] <= {prod[a][csr_pkg::FracW-1:0], {(csr_pkg::QuoW-csr_pkg::FracW){1'b0}}};
        quo[a] <= '0;
      end else if (state == ST_DIV) begin
        rem[a] <= fits[a] ? trial_diff[a][csr_pkg::SumW-1:0] : trial[a][csr_pkg::SumW-1:0];
        low[a] <= {low[a][csr_pkg::QuoW-2:0], 1'b0};
        quo[a] <= {quo[a][csr_pkg::QuoW-2:0], fits[a]};
      end
    end
    if (pop) begin
      eom <= q_job.eom;
    end
  end

  // Sequence one element and register its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      least_step <= csr_pkg::StepSat;
      m_tvalid   <= 1'b0;
    end else begin
      // Raise valid on a finished element, drop it once the transaction completes
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            cnt   <= csr_pkg::CntW'(csr_pkg::QuoW - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            least_step <= eom ? csr_pkg::StepSat : run_min;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      element_step <= el_min;
      running_step <= run_min;
      m_tlast      <= eom;
    end
  end

  assign m_tdata = {running_step, element_step};

endmodule

`default_nettype wire

>>> rtl/core/courant_step_reduction_unit.sv
// Top level of the Courant step reduction block.
// Depends on csr_pkg, csr_front, csr_queue and csr_back.
//
// Usage:
//   Slave stream s_*: one mesh node per transaction. s_tdata carries the
//   coordinates and velocities (signed Q16.16), s_tlast marks the last node
//   of an element, s_tuser[0] marks the last node of the mesh.
//   Master stream m_*: one transaction per closed element. m_tdata carries
//   the element's smallest axis step and the running minimum (unsigned
//   Q16.16, all ones when saturated); m_tlast is set on the end-of-mesh
//   result, after which the running minimum starts over.
// Throughput: the front end takes one node per cycle while the job queue has room.
//   Each closed element holds the divider through load, 32 quotient bits and
//   result; the three radix-2 divider lanes run side by side, and the next job is
//   taken from the queue only once the result is registered.
// Path: closing node, job queue, divider load, quotient steps, output register.
// Stalls: a two-entry job queue lets nodes flow while the divider works and
//   while a result waits on m_tready; s_tready drops only with the queue full.
// Reset: rst, synchronous, clears element state, the queue and the running
//   minimum; the block accepts nodes in the first cycle after reset.
`default_nettype none

module courant_step_reduction_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [191:0] s_tdata,  // node_x, node_y, node_z, vel_x, vel_y, vel_z
  input  wire logic         s_tlast,  // end_of_element
  input  wire logic [0:0]   s_tuser,  // end_of_mesh
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,  // element_step, running_step
  output logic              m_tlast   // final_result
);

  csr_pkg::q_status_t q_stat;
  csr_pkg::job_t      wr_job;
  csr_pkg::job_t      rd_job;
  logic               q_push;
  logic               q_pop;

  csr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (q_push),
    .job      (wr_job)
  );

  csr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  csr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_job    (rd_job),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_stat.valid)
    else $error("job popped from empty queue");

  // Running minimum never exceeds the element step it includes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:32] <= m_tdata[31:0]))
    else $error("running step above element step");

endmodule

`default_nettype wire
